// ===== rtl/vfc_pkg.sv =====
package vfc_pkg;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_PASS  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_t;

  localparam int CounterWidth = 19;
  localparam logic [CounterWidth-1:0] CounterMax = {CounterWidth{1'b1}};

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] pos_x;
    logic [7:0] pos_y;
    logic [3:0] pos_z;
  } req_t;

  typedef struct packed {
    logic                    is_solid;
    logic [5:0]              face_mask;
    logic [CounterWidth-1:0] face_base;
    logic [2:0]              face_total;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step_init;
    logic read;
    logic wr_row;
    logic clr_wr;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    cmd_t command;
    logic in_chunk;
    logic last_step;
    logic clear_last;
  } stat_t;

endpackage

// ===== rtl/voxel_face_culling.sv =====
// voxel face culling: one-bit occupancy map of a chunk with exposed-face query
// request channel: request is taken at a rising edge with start high and busy
// low; command marks a voxel, starts a meshing pass, queries a voxel or does
// nothing; response channel: done is high for exactly one cycle with response
// valid; the receiver cannot stall, so every result must be taken in that cycle
// the map is stored as one ram row per (x, y) holding all z bits, with one
// read and one write port; a query reads the center row and four neighbor
// rows one after another through the single read port
// a query inside the chunk steps through dispatch, reads of the center and
// four neighbor rows, drain and done; a mark through dispatch, a read of its
// row, drain, a row write and done (read-modify-write of a row); all other
// transactions go from dispatch to done; a new request is taken in the cycle
// done is high; after reset the map is swept to empty, one row per cycle,
// holding busy high until all CHUNK_EDGE * CHUNK_TALL rows (4096 by default)
// are cleared; the face counter resets to zero and saturates at its maximum
module voxel_face_culling #(
  parameter int CHUNK_EDGE = 16,
  parameter int CHUNK_TALL = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  vfc_pkg::req_t  request,
  output logic           done,
  output vfc_pkg::rsp_t  response
);

  vfc_pkg::ctrl_t ctl;
  vfc_pkg::stat_t status;

  vfc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .ctl    (ctl)
  );

  vfc_datapath #(
    .CHUNK_EDGE (CHUNK_EDGE),
    .CHUNK_TALL (CHUNK_TALL)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .ctl      (ctl),
    .status   (status),
    .response (response),
    .done     (done)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> done)
    else $error("finish did not produce a result");

  a_empty_no_faces: assert property (@(posedge clk) disable iff (rst)
    (done && !response.is_solid) |-> (response.face_mask == 6'd0 &&
                                      response.face_total == 3'd0))
    else $error("faces reported for an empty voxel");

endmodule

// ===== rtl/vfc_ram.sv =====
module vfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vfc_ctrl.sv =====
module vfc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  vfc_pkg::stat_t  status,
  output vfc_pkg::ctrl_t  ctl
);

  vfc_pkg::state_t state;
  vfc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vfc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vfc_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = vfc_pkg::ST_IDLE;
      end
      vfc_pkg::ST_IDLE: begin
        if (start) state_next = vfc_pkg::ST_DISPATCH;
      end
      vfc_pkg::ST_DISPATCH: begin
        if (status.in_chunk && (status.command == vfc_pkg::CMD_MARK ||
                                status.command == vfc_pkg::CMD_QUERY)) begin
          state_next = vfc_pkg::ST_READ;
        end else begin
          state_next = vfc_pkg::ST_DONE;
        end
      end
      vfc_pkg::ST_READ: begin
        if (status.last_step) state_next = vfc_pkg::ST_DRAIN;
      end
      vfc_pkg::ST_DRAIN: begin
        if (status.command == vfc_pkg::CMD_MARK) begin
          state_next = vfc_pkg::ST_WRITE;
        end else begin
          state_next = vfc_pkg::ST_DONE;
        end
      end
      vfc_pkg::ST_WRITE: state_next = vfc_pkg::ST_DONE;
      vfc_pkg::ST_DONE:  state_next = vfc_pkg::ST_IDLE;
      default:           state_next = vfc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      vfc_pkg::ST_CLEAR: ctl.clr_wr = 1'b1;
      vfc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      vfc_pkg::ST_DISPATCH: ctl.step_init = 1'b1;
      vfc_pkg::ST_READ:     ctl.read      = 1'b1;
      vfc_pkg::ST_DRAIN:    ctl           = '0;
      vfc_pkg::ST_WRITE:    ctl.wr_row    = 1'b1;
      vfc_pkg::ST_DONE:     ctl.finish    = 1'b1;
      default:              ctl           = '0;
    endcase
  end

endmodule

// ===== rtl/vfc_datapath.sv =====
module vfc_datapath #(
  parameter int CHUNK_EDGE = 16,
  parameter int CHUNK_TALL = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  vfc_pkg::req_t   request,
  input  vfc_pkg::ctrl_t  ctl,
  output vfc_pkg::stat_t  status,
  output vfc_pkg::rsp_t   response,
  output logic            done
);

  localparam int Rows = CHUNK_EDGE * CHUNK_TALL;
  localparam int AW   = $clog2(Rows);
  localparam int ZW   = $clog2(CHUNK_EDGE);

  localparam logic [2:0] StepCenter = 3'd0;
  localparam logic [2:0] StepTop    = 3'd1;
  localparam logic [2:0] StepBottom = 3'd2;
  localparam logic [2:0] StepRight  = 3'd3;
  localparam logic [2:0] StepLeft   = 3'd4;

  vfc_pkg::req_t req_q;
  logic [2:0]    step;
  logic [2:0]    step_q;
  logic          rd_q;
  logic          rd_ok_q;
  logic [AW-1:0] clear_addr;
  logic [CHUNK_EDGE-1:0] row_q;
  logic          solid_c;
  logic          nb_zp;
  logic          nb_zm;
  logic          nb_yp;
  logic          nb_ym;
  logic          nb_xp;
  logic          nb_xm;
  logic [vfc_pkg::CounterWidth-1:0] face_counter;

  logic [AW-1:0]         row_base;
  logic [AW-1:0]         raddr;
  logic                  rd_ok;
  logic                  in_chunk;
  logic [ZW-1:0]         z_idx;
  logic [ZW-1:0]         zp_idx;
  logic [ZW-1:0]         zm_idx;
  logic                  zp_ok;
  logic                  zm_ok;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CHUNK_EDGE-1:0] ram_wdata;
  logic [CHUNK_EDGE-1:0] rdata;
  logic [5:0]            mask;
  logic [2:0]            total;
  logic [vfc_pkg::CounterWidth:0] count_sum;
  logic                  is_query;

  assign in_chunk = (32'(req_q.pos_x) < CHUNK_EDGE) && (32'(req_q.pos_y) < CHUNK_TALL) &&
                    (32'(req_q.pos_z) < CHUNK_EDGE);
  assign row_base = AW'(32'(req_q.pos_y) * CHUNK_EDGE + 32'(req_q.pos_x));
  assign z_idx    = ZW'(req_q.pos_z);
  assign zp_idx   = ZW'(5'(req_q.pos_z) + 5'd1);
  assign zm_idx   = ZW'(req_q.pos_z - 4'd1);
  assign zp_ok    = (32'(req_q.pos_z) + 32'd1) < CHUNK_EDGE;
  assign zm_ok    = req_q.pos_z != 4'd0;
  assign is_query = req_q.command == vfc_pkg::CMD_QUERY;

  always_comb begin
    raddr = row_base;
    rd_ok = 1'b1;
    case (step)
      StepTop: begin
        raddr = row_base + AW'(CHUNK_EDGE);
        rd_ok = (32'(req_q.pos_y) + 32'd1) < CHUNK_TALL;
      end
      StepBottom: begin
        raddr = row_base - AW'(CHUNK_EDGE);
        rd_ok = req_q.pos_y != 8'd0;
      end
      StepRight: begin
        raddr = row_base + AW'(1);
        rd_ok = (32'(req_q.pos_x) + 32'd1) < CHUNK_EDGE;
      end
      StepLeft: begin
        raddr = row_base - AW'(1);
        rd_ok = req_q.pos_x != 4'd0;
      end
      default: begin
        raddr = row_base;
        rd_ok = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (ctl.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = ctl.wr_row;
      ram_waddr = row_base;
      ram_wdata = row_q | (CHUNK_EDGE'(1) << z_idx);
    end
  end

  vfc_ram #(
    .WIDTH (CHUNK_EDGE),
    .DEPTH (Rows)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.read && rd_ok),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= request;
    end
    if (rd_q) begin
      case (step_q)
        StepCenter: begin
          row_q   <= rdata;
          solid_c <= rdata[z_idx];
          nb_zp   <= zp_ok && rdata[zp_idx];
          nb_zm   <= zm_ok && rdata[zm_idx];
        end
        StepTop:    nb_yp <= rd_ok_q && rdata[z_idx];
        StepBottom: nb_ym <= rd_ok_q && rdata[z_idx];
        StepRight:  nb_xp <= rd_ok_q && rdata[z_idx];
        StepLeft:   nb_xm <= rd_ok_q && rdata[z_idx];
        default:    row_q <= row_q;
      endcase
    end
    step_q  <= step;
    rd_ok_q <= rd_ok;
  end

  assign mask      = (in_chunk && solid_c) ?
                     {~nb_xm, ~nb_xp, ~nb_zm, ~nb_zp, ~nb_ym, ~nb_yp} : 6'd0;
  assign total     = 3'($countones(mask));
  assign count_sum = {1'b0, face_counter} + (vfc_pkg::CounterWidth + 1)'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= StepCenter;
      rd_q         <= 1'b0;
      clear_addr   <= '0;
      face_counter <= '0;
      done         <= 1'b0;
    end else begin
      rd_q <= ctl.read;
      done <= ctl.finish;
      if (ctl.clr_wr) begin
        clear_addr <= clear_addr + AW'(1);
      end
      if (ctl.step_init) begin
        step <= StepCenter;
      end else if (ctl.read) begin
        step <= step + 3'd1;
      end
      if (ctl.finish) begin
        if (req_q.command == vfc_pkg::CMD_PASS) begin
          face_counter <= '0;
        end else if (is_query) begin
          face_counter <= count_sum[vfc_pkg::CounterWidth] ? vfc_pkg::CounterMax :
                          count_sum[vfc_pkg::CounterWidth-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      if (is_query) begin
        response.is_solid   <= in_chunk && solid_c;
        response.face_mask  <= mask;
        response.face_base  <= face_counter;
        response.face_total <= total;
      end else begin
        response <= '0;
      end
    end
  end

  assign status.command    = vfc_pkg::cmd_t'(req_q.command);
  assign status.in_chunk   = in_chunk;
  assign status.last_step  = (step == StepLeft) ||
                             (req_q.command == vfc_pkg::CMD_MARK && step == StepCenter);
  assign status.clear_last = 32'(clear_addr) == Rows - 1;

endmodule

// ===== tb/tb_voxel_face_culling.sv =====
`timescale 1ns / 1ps

module tb_voxel_face_culling;

  localparam int Edge = 16;
  localparam int Tall = 256;
  localparam int ReqBits = $bits(vfc_pkg::req_t);
  localparam int RandomItems = 1900;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic steady;
    vfc_pkg::req_t req;
  } slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  vfc_pkg::req_t request = '0;
  logic busy;
  logic done;
  vfc_pkg::rsp_t response;

  slot_t pending[$];
  vfc_pkg::rsp_t face_results[$];
  slot_t next_slot;

  bit occupied [0:Edge*Tall*Edge-1];
  logic [vfc_pkg::CounterWidth-1:0] face_count = '0;

  int errors = 0;
  int cycles = 0;
  int n_mark = 0, n_pass = 0, n_query = 0, n_solid = 0, n_nop = 0;
  int max_base = 0;
  bit saturated = 1'b0;

  voxel_face_culling #(
    .CHUNK_EDGE(Edge),
    .CHUNK_TALL(Tall)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .response(response)
  );

  always #2 clk = ~clk;

  function automatic bit solid_at(int x, int y, int z);
    if (x < 0 || x >= Edge || y < 0 || y >= Tall || z < 0 || z >= Edge) return 1'b0;
    return occupied[(y * Edge + x) * Edge + z];
  endfunction

  // updates map and counter, returns the expected response
  function automatic vfc_pkg::rsp_t face_result(vfc_pkg::req_t r);
    vfc_pkg::rsp_t res;
    logic [vfc_pkg::CounterWidth:0] sum;
    int x, y, z;
    res = '0;
    x = int'(r.pos_x);
    y = int'(r.pos_y);
    z = int'(r.pos_z);
    case (r.command)
      vfc_pkg::CMD_MARK: begin
        n_mark++;
        if (x < Edge && y < Tall && z < Edge) occupied[(y * Edge + x) * Edge + z] = 1'b1;
      end
      vfc_pkg::CMD_PASS: begin
        n_pass++;
        face_count = '0;
      end
      vfc_pkg::CMD_QUERY: begin
        n_query++;
        res.face_base = face_count;
        if (int'(face_count) > max_base) max_base = int'(face_count);
        if (face_count == vfc_pkg::CounterMax) saturated = 1'b1;
        if (solid_at(x, y, z)) begin
          n_solid++;
          res.is_solid = 1'b1;
          res.face_mask[0] = !solid_at(x, y + 1, z);
          res.face_mask[1] = !solid_at(x, y - 1, z);
          res.face_mask[2] = !solid_at(x, y, z + 1);
          res.face_mask[3] = !solid_at(x, y, z - 1);
          res.face_mask[4] = !solid_at(x + 1, y, z);
          res.face_mask[5] = !solid_at(x - 1, y, z);
          res.face_total = 3'($countones(res.face_mask));
          sum = face_count + res.face_total;
          face_count = (sum > vfc_pkg::CounterMax) ? vfc_pkg::CounterMax :
                       sum[vfc_pkg::CounterWidth-1:0];
        end
      end
      default: n_nop++;
    endcase
    return res;
  endfunction

  task automatic add(vfc_pkg::cmd_t c, int x, int y, int z, logic steady);
    slot_t s;
    s.steady = steady;
    s.req.command = c;
    s.req.pos_x = 4'(x);
    s.req.pos_y = 8'(y);
    s.req.pos_z = 4'(z);
    pending.insert(pending.size(), s);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        face_results.insert(face_results.size(), face_result(request));
      end
      if (!start || !busy) begin
        if (pending.size() != 0 && (pending[0].steady || $urandom_range(99) >= 28)) begin
          next_slot = pending.pop_front();
          request <= next_slot.req;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
          request <= ReqBits'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (face_results.size() == 0) begin
        errors++;
        $error("transaction with nothing expected");
      end else begin
        next_check(face_results.pop_front());
      end
    end
  end

  task automatic next_check(vfc_pkg::rsp_t e);
    if (response.is_solid !== e.is_solid) begin
      errors++;
      $error("is_solid expected %0d actual %0d", e.is_solid, response.is_solid);
    end
    if (response.face_mask !== e.face_mask) begin
      errors++;
      $error("face_mask expected %b actual %b", e.face_mask, response.face_mask);
    end
    if (response.face_base !== e.face_base) begin
      errors++;
      $error("face_base expected %0d actual %0d", e.face_base, response.face_base);
    end
    if (response.face_total !== e.face_total) begin
      errors++;
      $error("face_total expected %0d actual %0d", e.face_total, response.face_total);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int n, bx, by, bz, roll, x, y, z, next_region;
    logic steady;
    vfc_pkg::cmd_t c;

    // directed
    add(vfc_pkg::CMD_QUERY, 0, 0, 0, 1'b0);
    add(vfc_pkg::CMD_NOP, 15, 255, 15, 1'b0);
    add(vfc_pkg::CMD_MARK, 8, 128, 8, 1'b0);
    add(vfc_pkg::CMD_QUERY, 8, 128, 8, 1'b0);
    add(vfc_pkg::CMD_QUERY, 8, 128, 8, 1'b0);
    add(vfc_pkg::CMD_MARK, 0, 0, 0, 1'b0);
    add(vfc_pkg::CMD_QUERY, 0, 0, 0, 1'b0);
    add(vfc_pkg::CMD_MARK, 15, 255, 15, 1'b0);
    add(vfc_pkg::CMD_QUERY, 15, 255, 15, 1'b0);
    add(vfc_pkg::CMD_MARK, 8, 129, 8, 1'b0);
    add(vfc_pkg::CMD_MARK, 8, 127, 8, 1'b0);
    add(vfc_pkg::CMD_MARK, 8, 128, 9, 1'b0);
    add(vfc_pkg::CMD_MARK, 8, 128, 7, 1'b0);
    add(vfc_pkg::CMD_MARK, 9, 128, 8, 1'b0);
    add(vfc_pkg::CMD_MARK, 7, 128, 8, 1'b0);
    add(vfc_pkg::CMD_QUERY, 8, 128, 8, 1'b0);
    add(vfc_pkg::CMD_QUERY, 8, 129, 8, 1'b0);
    add(vfc_pkg::CMD_QUERY, 9, 128, 8, 1'b0);
    add(vfc_pkg::CMD_QUERY, 3, 200, 11, 1'b0);
    add(vfc_pkg::CMD_PASS, 15, 255, 15, 1'b0);
    add(vfc_pkg::CMD_QUERY, 8, 127, 8, 1'b0);
    add(vfc_pkg::CMD_NOP, 0, 0, 0, 1'b0);

    // random: mostly clustered marks, queries, passes and no-ops plus meshing sweeps
    n = 0;
    next_region = 0;
    while (n < RandomItems) begin
      if (n >= next_region) begin
        bx = $urandom_range(0, Edge - 4);
        by = $urandom_range(0, Tall - 4);
        bz = $urandom_range(0, Edge - 4);
        next_region = n + 120;
      end
      steady = (n >= 800 && n < 1200);
      roll = $urandom_range(99);
      if (roll < 6) begin
        add(vfc_pkg::CMD_PASS, $urandom, $urandom, $urandom, steady);
        for (int dy = 0; dy < 2; dy++)
          for (int dx = 0; dx < 4; dx++)
            for (int dz = 0; dz < 2; dz++)
              add(vfc_pkg::CMD_QUERY, bx + dx, by + dy, bz + dz, steady);
        n += 17;
      end else begin
        roll = $urandom_range(99);
        if (roll < 35) c = vfc_pkg::CMD_MARK;
        else if (roll < 40) c = vfc_pkg::CMD_PASS;
        else if (roll < 90) c = vfc_pkg::CMD_QUERY;
        else c = vfc_pkg::CMD_NOP;
        if ($urandom_range(99) < 80) begin
          x = bx + $urandom_range(0, 3);
          y = by + $urandom_range(0, 3);
          z = bz + $urandom_range(0, 3);
        end else begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end
        add(c, x, y, z, steady);
        n++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start) @(negedge clk);
    while (face_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("ran %0d marks, %0d passes, %0d queries (%0d on solid voxels), %0d no-ops",
             n_mark, n_pass, n_query, n_solid, n_nop);
    $display("highest face base %0d, counter saturation %s",
             max_base, saturated ? "reached" : "not reached");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
